// ----- rtl/core/mpg_pkg.sv -----
// package for the multiset permutation generator
// shared constants, sequencer states and the result item type; no dependencies
`timescale 1ns / 1ps

package mpg_pkg;

  // defaults for the top level parameters
  localparam int MAX_N_DEF      = 8;
  localparam int VALUE_BITS_DEF = 8;

  // width of the value fields on the ports
  localparam int IO_BITS = 8;

  // input function codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_REQ  = 1'b1;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_EM_RD,
    ST_EM_LD,
    ST_PV_RD,
    ST_PV_CMP,
    ST_JS_RD,
    ST_JS_CMP,
    ST_SW_P,
    ST_SW_J,
    ST_RV_LO,
    ST_RV_HI,
    ST_RV_WL,
    ST_RV_WH,
    ST_DONE
  } seq_state_t;

  // one result item
  typedef struct packed {
    logic [IO_BITS-1:0] value;
    logic               last;
    logic               done;
  } res_item_t;

  // load request from the sequencer into the output stage
  typedef struct packed {
    logic      load;
    res_item_t item;
  } out_req_t;

endpackage

// ----- rtl/core/mpg_store.sv -----
// element store: one write port, one read port, registered read data
// depends on nothing but its parameters
`timescale 1ns / 1ps

module mpg_store #(
  parameter int DEPTH = 8,
  parameter int AW    = 3,
  parameter int DW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/mpg_out.sv -----
// output register stage for result items
// uses mpg_pkg for the result item type
`timescale 1ns / 1ps

module mpg_out (
  input  logic                       clk,
  input  logic                       rst,
  input  mpg_pkg::out_req_t          req,
  output logic                       free,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [mpg_pkg::IO_BITS-1:0] out_value,
  output logic                       out_last,
  output logic                       done_res
);
  import mpg_pkg::*;

  res_item_t item;

  // slot can take a new item when empty or being drained
  assign free = !out_valid || out_ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (req.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (req.load) begin
      item <= req.item;
    end
  end

  assign out_value = item.value;
  assign out_last  = item.last;
  assign done_res  = item.done;

endmodule

// ----- rtl/core/mpg_seq.sv -----
// sequencer: sorted insertion, emission and next-permutation steps on the store
// uses mpg_pkg for states, codes and the result item type
`timescale 1ns / 1ps

module mpg_seq #(
  parameter int MAX_N      = mpg_pkg::MAX_N_DEF,
  parameter int VALUE_BITS = mpg_pkg::VALUE_BITS_DEF,
  parameter int AW         = (MAX_N > 1) ? $clog2(MAX_N) : 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              func,
  input  logic signed [mpg_pkg::IO_BITS-1:0] in_value,
  input  logic                              in_last,
  output logic                              mem_we,
  output logic [AW-1:0]                     mem_waddr,
  output logic [VALUE_BITS-1:0]             mem_wdata,
  output logic                              mem_re,
  output logic [AW-1:0]                     mem_raddr,
  input  logic [VALUE_BITS-1:0]             mem_rdata,
  output mpg_pkg::out_req_t                 out_req,
  input  logic                              out_free
);
  import mpg_pkg::*;

  localparam int CW = $clog2(MAX_N + 1);

  seq_state_t            state, state_next;
  logic [CW-1:0]         count, count_next;
  logic                  closed, closed_next;
  logic                  exhausted, exhausted_next;
  logic [AW-1:0]         idx_a, idx_a_next;
  logic [AW-1:0]         idx_b, idx_b_next;
  logic [VALUE_BITS-1:0] val_a, val_a_next;
  logic [VALUE_BITS-1:0] val_b, val_b_next;

  logic [CW-1:0]         eff_cnt;
  logic [AW-1:0]         last_idx;
  logic [AW-1:0]         lo_inc;
  logic [AW-1:0]         hi_dec;
  logic [VALUE_BITS-1:0] in_conv;

  // input value taken from the low bits of the 8-bit field
  assign in_conv  = VALUE_BITS'($unsigned(in_value));
  // a load after a closed set starts from an empty store
  assign eff_cnt  = closed ? '0 : count;
  assign last_idx = AW'(count - CW'(1));
  assign lo_inc   = idx_b + AW'(1);
  assign hi_dec   = idx_a - AW'(1);

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      closed    <= 1'b0;
      exhausted <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      closed    <= closed_next;
      exhausted <= exhausted_next;
    end
  end

  // working indexes and values
  always_ff @(posedge clk) begin
    idx_a <= idx_a_next;
    idx_b <= idx_b_next;
    val_a <= val_a_next;
    val_b <= val_b_next;
  end

  // next state, memory accesses and result loads
  always_comb begin
    state_next     = state;
    count_next     = count;
    closed_next    = closed;
    exhausted_next = exhausted;
    idx_a_next     = idx_a;
    idx_b_next     = idx_b;
    val_a_next     = val_a;
    val_b_next     = val_b;
    in_ready       = (state == ST_IDLE);
    mem_we         = 1'b0;
    mem_waddr      = idx_a;
    mem_wdata      = val_a;
    mem_re         = 1'b0;
    mem_raddr      = idx_a;
    out_req        = '0;

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (func == FUNC_LOAD) begin
            if (closed) begin
              count_next     = '0;
              closed_next    = 1'b0;
              exhausted_next = 1'b0;
            end
            if (in_last) begin
              closed_next = 1'b1;
            end
            // full store drops the value
            if (eff_cnt < CW'(MAX_N)) begin
              idx_a_next = AW'(eff_cnt);
              val_b_next = in_conv;
              state_next = ST_INS_RD;
            end
          end else begin
            if (!closed || exhausted || count == '0) begin
              state_next = ST_DONE;
            end else begin
              idx_a_next = '0;
              state_next = ST_EM_RD;
            end
          end
        end
      end

      // insertion: shift larger entries up one place
      ST_INS_RD: begin
        if (idx_a == '0) begin
          mem_we     = 1'b1;
          mem_waddr  = idx_a;
          mem_wdata  = val_b;
          count_next = count + CW'(1);
          state_next = ST_IDLE;
        end else begin
          mem_re     = 1'b1;
          mem_raddr  = hi_dec;
          state_next = ST_INS_CMP;
        end
      end

      ST_INS_CMP: begin
        mem_we    = 1'b1;
        mem_waddr = idx_a;
        if ($signed(mem_rdata) > $signed(val_b)) begin
          mem_wdata  = mem_rdata;
          idx_a_next = hi_dec;
          state_next = ST_INS_RD;
        end else begin
          mem_wdata  = val_b;
          count_next = count + CW'(1);
          state_next = ST_IDLE;
        end
      end

      // emission: one element per result item
      ST_EM_RD: begin
        mem_re     = 1'b1;
        mem_raddr  = idx_a;
        state_next = ST_EM_LD;
      end

      ST_EM_LD: begin
        if (out_free) begin
          out_req.load       = 1'b1;
          out_req.item.value = IO_BITS'(mem_rdata);
          out_req.item.last  = (idx_a == last_idx);
          out_req.item.done  = 1'b0;
          if (idx_a == last_idx) begin
            if (count <= CW'(1)) begin
              exhausted_next = 1'b1;
              state_next     = ST_IDLE;
            end else begin
              idx_a_next = last_idx;
              state_next = ST_PV_RD;
            end
          end else begin
            idx_a_next = idx_a + AW'(1);
            state_next = ST_EM_RD;
          end
        end
      end

      // pivot search from the end: first entry below its right neighbor
      ST_PV_RD: begin
        mem_re     = 1'b1;
        mem_raddr  = idx_a;
        state_next = ST_PV_CMP;
      end

      ST_PV_CMP: begin
        if (idx_a == last_idx) begin
          val_a_next = mem_rdata;
          idx_a_next = hi_dec;
          state_next = ST_PV_RD;
        end else if ($signed(mem_rdata) < $signed(val_a)) begin
          idx_b_next = idx_a;
          val_b_next = mem_rdata;
          idx_a_next = last_idx;
          state_next = ST_JS_RD;
        end else if (idx_a == '0) begin
          exhausted_next = 1'b1;
          state_next     = ST_IDLE;
        end else begin
          val_a_next = mem_rdata;
          idx_a_next = hi_dec;
          state_next = ST_PV_RD;
        end
      end

      // rightmost entry greater than the pivot
      ST_JS_RD: begin
        mem_re     = 1'b1;
        mem_raddr  = idx_a;
        state_next = ST_JS_CMP;
      end

      ST_JS_CMP: begin
        if ($signed(mem_rdata) > $signed(val_b)) begin
          val_a_next = mem_rdata;
          state_next = ST_SW_P;
        end else begin
          idx_a_next = hi_dec;
          state_next = ST_JS_RD;
        end
      end

      // swap pivot with the found entry
      ST_SW_P: begin
        mem_we     = 1'b1;
        mem_waddr  = idx_b;
        mem_wdata  = val_a;
        state_next = ST_SW_J;
      end

      ST_SW_J: begin
        mem_we     = 1'b1;
        mem_waddr  = idx_a;
        mem_wdata  = val_b;
        idx_b_next = lo_inc;
        idx_a_next = last_idx;
        state_next = (lo_inc < last_idx) ? ST_RV_LO : ST_IDLE;
      end

      // suffix reversal, one pair per pass through RV_LO, RV_HI, RV_WL and RV_WH
      ST_RV_LO: begin
        mem_re     = 1'b1;
        mem_raddr  = idx_b;
        state_next = ST_RV_HI;
      end

      ST_RV_HI: begin
        mem_re     = 1'b1;
        mem_raddr  = idx_a;
        val_a_next = mem_rdata;
        state_next = ST_RV_WL;
      end

      ST_RV_WL: begin
        mem_we     = 1'b1;
        mem_waddr  = idx_b;
        mem_wdata  = mem_rdata;
        state_next = ST_RV_WH;
      end

      ST_RV_WH: begin
        mem_we     = 1'b1;
        mem_waddr  = idx_a;
        mem_wdata  = val_a;
        idx_b_next = lo_inc;
        idx_a_next = hi_dec;
        state_next = (lo_inc < hi_dec) ? ST_RV_LO : ST_IDLE;
      end

      // single done result
      ST_DONE: begin
        if (out_free) begin
          out_req.load       = 1'b1;
          out_req.item.value = '0;
          out_req.item.last  = 1'b1;
          out_req.item.done  = 1'b1;
          state_next         = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/multiset_permutation_generator.sv -----
// Multiset permutation generator, top level.
// A load item (func = 0) inserts in_value into a store kept in ascending
// order; in_last closes the set, and a load after a closed set starts a new
// one. Loads into a full store are dropped but still honor in_last. Loads
// give no result.
// A request item (func = 1) returns the current permutation as one result
// item per element, out_last on the final one, then steps the store to the
// next distinct permutation in lexicographic order. A request on an open,
// empty or finished set returns one item with done_res and out_last set.
// Both channels are valid/ready. The block takes one item at a time; in_ready
// is high only while the sequencer is idle. A load reads and rewrites each
// entry that moves up, then writes the new value. A request reads and emits
// each element, then reads through the pivot search and the swap search,
// writes the swap pair, and reads and rewrites each reversed pair in turn.
// These steps come from the single read port and single write port of the
// element store. Output stalls hold the sequencer in its emission step and
// its done step; the output register lets the last result wait while the
// next item is taken.
// Synchronous reset empties the set and clears the output valid.
`timescale 1ns / 1ps

module multiset_permutation_generator #(
  parameter int MAX_N      = mpg_pkg::MAX_N_DEF,
  parameter int VALUE_BITS = mpg_pkg::VALUE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               func,
  input  logic signed [mpg_pkg::IO_BITS-1:0] in_value,
  input  logic                               in_last,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [mpg_pkg::IO_BITS-1:0] out_value,
  output logic                               out_last,
  output logic                               done_res
);
  import mpg_pkg::*;

  localparam int AW = (MAX_N > 1) ? $clog2(MAX_N) : 1;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [VALUE_BITS-1:0] mem_wdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;
  logic [VALUE_BITS-1:0] mem_rdata;
  out_req_t              out_req;
  logic                  out_free;
  logic [IO_BITS-1:0]    out_value_raw;

  // element store
  mpg_store #(
    .DEPTH (MAX_N),
    .AW    (AW),
    .DW    (VALUE_BITS)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // sequencer
  mpg_seq #(
    .MAX_N      (MAX_N),
    .VALUE_BITS (VALUE_BITS),
    .AW         (AW)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .in_value  (in_value),
    .in_last   (in_last),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .out_req   (out_req),
    .out_free  (out_free)
  );

  // output register
  mpg_out u_out (
    .clk       (clk),
    .rst       (rst),
    .req       (out_req),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_value (out_value_raw),
    .out_last  (out_last),
    .done_res  (done_res)
  );

  assign out_value = $signed(out_value_raw);

endmodule

// ----- rtl/core/mpg_check.sv -----
// port-level checks for the multiset permutation generator, bound to the top
// uses mpg_pkg for the function codes
`timescale 1ns / 1ps

module mpg_check (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               func,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [mpg_pkg::IO_BITS-1:0] out_value,
  input logic                               out_last,
  input logic                               done_res
);
  import mpg_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_value) &&
      $stable(out_last) && $stable(done_res))
    else $error("result item changed while stalled");

  // a done result is a lone zero item closing its group
  a_done_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> out_last && out_value == '0)
    else $error("done item malformed");

  // an accepted request always leaves in_ready low in the cycle after it
  a_req_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && func == FUNC_REQ |=> !in_ready)
    else $error("input ready right after a request item");

  // reset empties the output register
  a_rst_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind multiset_permutation_generator mpg_check u_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .func      (func),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_value (out_value),
  .out_last  (out_last),
  .done_res  (done_res)
);

// ----- verif/mpg_checker.sv -----
// checker for the multiset permutation generator
// watches both channels, predicts result items from accepted input items
// and compares; uses mpg_pkg
`timescale 1ns / 1ps

module mpg_checker #(
  parameter int MAX_N = mpg_pkg::MAX_N_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic                               func,
  input  logic signed [mpg_pkg::IO_BITS-1:0] in_value,
  input  logic                               in_last,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic signed [mpg_pkg::IO_BITS-1:0] out_value,
  input  logic                               out_last,
  input  logic                               done_res,
  output int                                 fail_count,
  output int                                 pending
);
  import mpg_pkg::*;

  // predicted copy of the sorted set and its flags
  logic signed [IO_BITS-1:0] held [MAX_N];
  int                        held_count;
  bit                        closed;
  bit                        spent;
  res_item_t                 perm_results_q[$];

  // step the held set to the next distinct arrangement, 0 when none is left
  function automatic bit step_permutation();
    int                        piv;
    int                        j;
    int                        lo;
    int                        hi;
    logic signed [IO_BITS-1:0] t;
    if (held_count < 2) return 1'b0;
    piv = held_count - 1;
    while (piv > 0 && held[piv-1] >= held[piv]) piv--;
    if (piv == 0) return 1'b0;
    piv--;
    j = held_count - 1;
    while (held[j] <= held[piv]) j--;
    t = held[piv];
    held[piv] = held[j];
    held[j] = t;
    lo = piv + 1;
    hi = held_count - 1;
    while (lo < hi) begin
      t = held[lo];
      held[lo] = held[hi];
      held[hi] = t;
      lo++;
      hi--;
    end
    return 1'b1;
  endfunction

  // apply one accepted item and queue the permutation items it gives
  function automatic void take_item(logic f, logic signed [IO_BITS-1:0] v, logic l);
    res_item_t r;
    int        pos;
    int        i;
    if (f == FUNC_LOAD) begin
      // a load after a closed set opens a fresh one
      if (closed) begin
        held_count = 0;
        closed = 1'b0;
        spent = 1'b0;
      end
      // sorted insert, dropped when full
      if (held_count < MAX_N) begin
        pos = held_count;
        while (pos > 0 && held[pos-1] > v) begin
          held[pos] = held[pos-1];
          pos--;
        end
        held[pos] = v;
        held_count++;
      end
      if (l) closed = 1'b1;
    end else if (!closed || spent || held_count == 0) begin
      // open, empty or finished set answers done
      r.value = '0;
      r.last = 1'b1;
      r.done = 1'b1;
      perm_results_q.insert(perm_results_q.size(), r);
    end else begin
      for (i = 0; i < held_count; i++) begin
        r.value = held[i];
        r.last = (i == held_count - 1);
        r.done = 1'b0;
        perm_results_q.insert(perm_results_q.size(), r);
      end
      if (!step_permutation()) spent = 1'b1;
    end
  endfunction

  // compare results first, then predict from the item taken at the same edge
  always @(posedge clk) begin
    res_item_t want;
    if (rst) begin
      held_count = 0;
      closed = 1'b0;
      spent = 1'b0;
      perm_results_q.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (perm_results_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected item, expected none, got value %0d last %0b done %0b",
                   $time, out_value, out_last, done_res);
        end else begin
          want = perm_results_q.pop_front();
          if (out_value !== want.value) begin
            fail_count++;
            $display("%0t: out_value expected %0d got %0d",
                     $time, $signed(want.value), out_value);
          end
          if (out_last !== want.last) begin
            fail_count++;
            $display("%0t: out_last expected %0b got %0b", $time, want.last, out_last);
          end
          if (done_res !== want.done) begin
            fail_count++;
            $display("%0t: done_res expected %0b got %0b", $time, want.done, done_res);
          end
        end
      end
      if (in_valid && in_ready) take_item(func, in_value, in_last);
    end
    pending = perm_results_q.size();
  end

endmodule

// ----- verif/tb_multiset_permutation_generator.sv -----
// testbench top for the multiset permutation generator
// drives directed and random load/request items with random stalls; depends on mpg_pkg,
// the block and mpg_checker
`timescale 1ns / 1ps

module tb_multiset_permutation_generator;
  import mpg_pkg::*;

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      in_valid  = 1'b0;
  logic                      in_ready;
  logic                      func      = FUNC_LOAD;
  logic signed [IO_BITS-1:0] in_value  = '0;
  logic                      in_last   = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [IO_BITS-1:0] out_value;
  logic                      out_last;
  logic                      done_res;
  int                        fail_count;
  int                        pending;
  int                        sent      = 0;
  bit                        quiet     = 1'b0;

  always #1 clk = ~clk;

  multiset_permutation_generator uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .in_value(in_value), .in_last(in_last),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_value(out_value), .out_last(out_last), .done_res(done_res)
  );

  mpg_checker perm_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .in_value(in_value), .in_last(in_last),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_value(out_value), .out_last(out_last), .done_res(done_res),
    .fail_count(fail_count), .pending(pending)
  );

  // receiver stalls, none during the quiet stretch
  always @(negedge clk) begin
    out_ready <= quiet || ($urandom_range(0, 99) >= 13);
  end

  // present one item after a random gap and hold it until taken
  task automatic send_item(input logic f, input logic signed [IO_BITS-1:0] v, input logic l);
    @(negedge clk);
    while (!quiet && $urandom_range(0, 99) < 13) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    in_value <= v;
    in_last <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  // hold off the sender until every predicted item has come back
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // narrow values give many duplicates, wide ones cover every bit
  function automatic logic signed [IO_BITS-1:0] pick_value(bit narrow);
    logic [IO_BITS-1:0] r;
    if (narrow) r = IO_BITS'($urandom_range(0, 3) + 254);
    else r = IO_BITS'($urandom_range(0, 255));
    return r;
  endfunction

  task automatic load_set(int n, bit narrow, bit close);
    int i;
    for (i = 0; i < n; i++) send_item(FUNC_LOAD, pick_value(narrow), close && (i == n - 1));
  endtask

  task automatic request_perms(int k);
    repeat (k) send_item(FUNC_REQ, pick_value(1'b0), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int pick;
    int n;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // request right after reset, set still open
    request_perms(1);
    // two extreme values: both orders, then done
    send_item(FUNC_LOAD, 8'sh7f, 1'b0);
    send_item(FUNC_LOAD, 8'sh80, 1'b1);
    request_perms(3);
    // request on an open set, then a duplicate pair with a single order
    send_item(FUNC_LOAD, 8'sh05, 1'b0);
    request_perms(1);
    send_item(FUNC_LOAD, 8'sh05, 1'b1);
    request_perms(2);
    // single element set
    send_item(FUNC_LOAD, 8'sh00, 1'b1);
    request_perms(2);
    wait_drained();
    // overfilled store: the ninth value is dropped but its last flag closes
    load_set(8, 1'b0, 1'b0);
    send_item(FUNC_LOAD, 8'sh7f, 1'b1);
    request_perms(1);
    wait_drained();

    // random sets, mostly well formed with some stray and open-set requests
    while (sent < 150) begin
      quiet = (sent >= 90 && sent < 120);
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        request_perms(1);
      end else if (pick < 16) begin
        load_set($urandom_range(1, 3), 1'b1, 1'b0);
        request_perms(1);
      end else begin
        n = $urandom_range(0, 19);
        if (n < 12) n = $urandom_range(1, 4);
        else if (n < 18) n = $urandom_range(5, 8);
        else n = $urandom_range(9, 10);
        load_set(n, $urandom_range(0, 2) != 0, 1'b1);
        request_perms($urandom_range(1, 8));
      end
      if ($urandom_range(0, 5) == 0) wait_drained();
    end
    quiet = 1'b0;

    // drain, then give stray items time to show up
    wait_drained();
    repeat (200) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_multiset_permutation_generator OK");
    end else begin
      $display("tb_multiset_permutation_generator NOT OK");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #1000000;
    $display("tb_multiset_permutation_generator NOT OK");
    $finish;
  end

endmodule

// ----- multiset_permutation_generator.f -----
rtl/core/mpg_pkg.sv
rtl/core/mpg_store.sv
rtl/core/mpg_out.sv
rtl/core/mpg_seq.sv
rtl/core/multiset_permutation_generator.sv
rtl/core/mpg_check.sv
verif/mpg_checker.sv
verif/tb_multiset_permutation_generator.sv
